[design/fpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 4;
    localparam int FRAC_BITS_DF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_LT   = 4'd4,
        OP_GT   = 4'd5,
        OP_LE   = 4'd6,
        OP_GE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FROM = 4'd14,
        OP_TOI  = 4'd15
    } t_op;

    // per-item control that rides beside the divider
    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  res;
        logic               truth;
        logic               dz;
        logic               neg;
    } t_side;

endpackage

[design/fpa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels for ALU requests and responses.
// ----------------------------------------------------------------------------
interface fpa_req_if;
    logic                valid;
    logic                ready;
    logic [3:0]          op;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  result;
    logic                truth;
    logic                div_by_zero;

    modport source (output valid, result, truth, div_by_zero, input ready);
    modport sink   (input valid, result, truth, div_by_zero, output ready);
endinterface

[design/fpa_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined restoring divider, one quotient bit per stage, low 32 bits kept.
// ----------------------------------------------------------------------------
module fpa_divider #(
    parameter int NUM_W = 40
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [fpa_pkg::DATA_W-1:0] i_den,
    output logic [fpa_pkg::DATA_W-1:0] o_quo
);
    import fpa_pkg::*;

    logic [DATA_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0]  r_num [NUM_W];
    logic [DATA_W-1:0] r_quo [NUM_W];
    logic [DATA_W-1:0] r_den [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DATA_W-1:0] p_rem, p_quo, p_den;
        logic [NUM_W-1:0]  p_num;
        logic [DATA_W:0]   trial;
        logic              ge;
        logic [DATA_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_num = i_num;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
            assign p_num = r_num[k-1];
        end

        always_comb begin
            trial = {p_rem, p_num[NUM_W-1]};
            ge    = trial >= {1'b0, p_den};
            n_rem = ge ? DATA_W'(trial - {1'b0, p_den}) : trial[DATA_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= {p_quo[DATA_W-2:0], ge};
                r_den[k] <= p_den;
                r_num[k] <= p_num << 1;
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

[design/fixed_point_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Pipelined signed Q(32-F).F fixed-point ALU.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while not stalled and returns one response
// per request, in order. The default format is Q24.8. Every op runs the full
// length so order is kept; the length is set by the divider, which resolves
// one quotient bit per stage over 32 + FRAC_BITS stages. The whole pipe
// advances whenever the output register is empty or being drained, so a
// held response stalls everything without loss.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpa_req_if.sink    i_req,
    fpa_rsp_if.source  o_rsp
);
    import fpa_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;

    logic en;

    // stage A: decode, simple ops, raw product, divider operands
    logic                r_a_valid;
    t_side               r_a_side;
    logic signed [63:0]  r_a_prod;
    logic [NUM_W-1:0]    r_a_num;
    logic [DATA_W-1:0]   r_a_den;

    t_side               n_a_side;
    logic signed [31:0]  sa, sb;
    logic [DATA_W-1:0]   mag_a;

    // side line aligned with the divider
    logic [NUM_W-1:0]    r_vld;
    t_side               r_side [NUM_W];
    t_side               n_side0;
    logic [63:0]         prod_mag;
    logic [63:0]         prod_shr;

    logic [DATA_W-1:0]   quo;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_res;
    logic                r_out_truth, r_out_dz;
    logic [DATA_W-1:0]   n_out_res;
    t_side               last;

    assign en          = ~r_out_valid | o_rsp.ready;
    assign i_req.ready = en;

    always_comb begin
        sa = i_req.operand_a;
        sb = i_req.operand_b;
        n_a_side       = '0;
        n_a_side.op    = t_op'(i_req.op);
        n_a_side.neg   = sa[31] ^ sb[31];
        case (t_op'(i_req.op))
            OP_ADD:  n_a_side.res = sa + sb;
            OP_SUB:  n_a_side.res = sa - sb;
            OP_DIV:  n_a_side.dz  = (sb == 32'sd0);
            OP_LT:   n_a_side.truth = sa <  sb;
            OP_GT:   n_a_side.truth = sa >  sb;
            OP_LE:   n_a_side.truth = sa <= sb;
            OP_GE:   n_a_side.truth = sa >= sb;
            OP_EQ:   n_a_side.truth = sa == sb;
            OP_NE:   n_a_side.truth = sa != sb;
            OP_MIN:  n_a_side.res = (sb < sa) ? sb : sa;
            OP_MAX:  n_a_side.res = (sb > sa) ? sb : sa;
            OP_INC:  n_a_side.res = sa + 32'sd1;
            OP_DEC:  n_a_side.res = sa - 32'sd1;
            OP_FROM: n_a_side.res = sa << FRAC_BITS;
            OP_TOI:  n_a_side.res = sa >>> FRAC_BITS;
            default: n_a_side.res = '0;   // multiply filled in next stage
        endcase
        mag_a = sa[31] ? DATA_W'(-sa) : DATA_W'(sa);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
            r_a_prod <= sa * sb;
            r_a_num  <= {mag_a, {FRAC_BITS{1'b0}}};
            r_a_den  <= sb[31] ? DATA_W'(-sb) : DATA_W'(sb);
        end
    end

    // multiply post: truncate toward zero, wrap to 32 bits
    always_comb begin
        prod_mag = r_a_prod[63] ? 64'(-r_a_prod) : 64'(r_a_prod);
        prod_shr = prod_mag >> FRAC_BITS;
        n_side0  = r_a_side;
        if (r_a_side.op == OP_MUL) begin
            n_side0.res = r_a_prod[63] ? DATA_W'(-prod_shr[DATA_W-1:0])
                                       : prod_shr[DATA_W-1:0];
        end
    end

    fpa_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_num),
        .i_den (r_a_den),
        .o_quo (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_W-2:0], r_a_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < NUM_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // output select: divide result gets its sign here
    always_comb begin
        last = r_side[NUM_W-1];
        if (last.op == OP_DIV) begin
            if (last.dz) begin
                n_out_res = '0;
            end else begin
                n_out_res = last.neg ? DATA_W'(-quo) : quo;
            end
        end else begin
            n_out_res = last.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res   <= n_out_res;
            r_out_truth <= last.truth;
            r_out_dz    <= last.dz;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result      = r_out_res;
    assign o_rsp.truth       = r_out_truth;
    assign o_rsp.div_by_zero = r_out_dz;

endmodule

[design/fpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_result,
    input logic        i_out_truth,
    input logic        i_out_dz
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result))
        else $error("response dropped while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request side stalled with empty output");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dz |-> i_out_result == 32'd0 && !i_out_truth)
        else $error("divide by zero response not cleared");

    a_truth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_truth |-> i_out_result == 32'd0 && !i_out_dz)
        else $error("comparison response carries a result");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_result (o_rsp.result),
    .i_out_truth  (o_rsp.truth),
    .i_out_dz     (o_rsp.div_by_zero)
);
